>>> hdl/ordered_list_engine_unit_macros.svh
// Assertion macros shared by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define OLE_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list engine assertion failed");

// Condition implies consequence in the next cycle.
`define OLE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list engine assertion failed");

`endif

>>> hdl/ole_pkg.sv
// Package with sizes and codes of the ordered list engine.
`timescale 1ns / 1ps
`default_nettype none
package ole_pkg;
   localparam int CAPACITY = 16;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int STAT_W   = 2;
   localparam int ECNT_W   = 5;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 104;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_KEY   = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;
endpackage
`default_nettype wire

>>> hdl/ordered_list_engine_unit.sv
// Ordered list engine: sequenced insert and delete over a value RAM.
// An insert shifts the entries at and above the index up, then writes the
// item; a delete reads the entry out, then shifts the entries above it down;
// a key delete searches first. One item at a time: a request is taken in idle
// only; the single RAM port pair moves one entry a cycle.
// Reset: synchronous, active high; clears count, sequencer, pending flag and response valid.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_engine_unit_macros.svh"
module ordered_list_engine_unit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // opcode[2:0], item_value[34:3], position[39:35]
   input  wire logic [ole_pkg::REQ_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // status[1:0], entry_count[6:2], front_value[38:7], back_value[70:39],
   // removed_value[102:71], zero pad[103]
   output logic      [ole_pkg::RSP_W-1:0] rsp_tdata
);
   import ole_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MOVE   = 4'd1;
   localparam logic [3:0] S_PUT    = 4'd2;
   localparam logic [3:0] S_FETCH  = 4'd3;
   localparam logic [3:0] S_TAKE   = 4'd4;
   localparam logic [3:0] S_SEARCH = 4'd5;
   localparam logic [3:0] S_RD0    = 4'd6;
   localparam logic [3:0] S_RD1    = 4'd7;
   localparam logic [3:0] S_RD2    = 4'd8;
   localparam logic [3:0] S_RESP   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic              up_ff, up_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pdst_ff, pdst_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [VAL_W-1:0]  removed_ff, removed_in;
   logic [VAL_W-1:0]  front_ff, front_in;
   logic [VAL_W-1:0]  back_ff, back_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [VAL_W-1:0]  wr_data, rd_data;

   logic [OP_W-1:0]   req_op;
   logic [VAL_W-1:0]  req_val;
   logic [POS_W-1:0]  req_pos;
   logic              req_fire;
   logic [CNT_W-1:0]  count_m1;
   logic [CMP_W-1:0]  pos_u;
   logic [CMP_W-1:0]  last_u;
   logic [CNT_W-1:0]  ins_idx;
   logic [ADDR_W-1:0] tidx;
   logic              is_insert;
   logic              is_delete;

   assign req_op   = req_tdata[OP_W-1:0];
   assign req_val  = req_tdata[OP_W+VAL_W-1:OP_W];
   assign req_pos  = req_tdata[OP_W+VAL_W+POS_W-1:OP_W+VAL_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign count_m1 = count_ff - CNT_W'(1);
   assign pos_u    = CMP_W'(req_pos[POS_W-2:0]);
   assign last_u   = CMP_W'(count_m1);
   assign is_insert = (req_op == OP_INS_FRONT) || (req_op == OP_INS_BACK) ||
                      (req_op == OP_INS_POS);
   assign is_delete = (req_op == OP_DEL_FRONT) || (req_op == OP_DEL_BACK) ||
                      (req_op == OP_DEL_KEY);
   assign tidx = (state_ff == S_TAKE) ? idx_ff : pdst_ff;

   always_comb begin
      priority if (req_op == OP_INS_FRONT) begin
         ins_idx = '0;
      end else if (req_op == OP_INS_BACK) begin
         ins_idx = count_ff;
      end else if (req_pos[POS_W-1] || (count_ff == '0)) begin
         ins_idx = '0;
      end else if (pos_u > last_u) begin
         ins_idx = count_ff;
      end else begin
         ins_idx = CNT_W'(pos_u) + CNT_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      src_in       = src_ff;
      left_in      = left_ff;
      up_in        = up_ff;
      pend_in      = pend_ff;
      pdst_in      = pdst_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = src_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               val_in     = req_val;
               status_in  = ST_OK;
               removed_in = '0;
               pend_in    = 1'b0;
               priority if (is_insert && (count_ff == CNT_W'(CAPACITY))) begin
                  status_in = ST_FULL;
                  state_in  = S_RD0;
               end else if (is_insert) begin
                  idx_in   = ADDR_W'(ins_idx);
                  up_in    = 1'b1;
                  src_in   = ADDR_W'(count_m1);
                  left_in  = count_ff - ins_idx;
                  state_in = S_MOVE;
               end else if (is_delete && (count_ff == '0)) begin
                  status_in = ST_EMPTY;
                  state_in  = S_RD0;
               end else if (req_op == OP_DEL_FRONT) begin
                  idx_in   = '0;
                  state_in = S_FETCH;
               end else if (req_op == OP_DEL_BACK) begin
                  idx_in   = ADDR_W'(count_m1);
                  state_in = S_FETCH;
               end else if (req_op == OP_DEL_KEY) begin
                  src_in   = '0;
                  left_in  = count_ff;
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            removed_in = rd_data;
            up_in      = 1'b0;
            pend_in    = 1'b0;
            src_in     = tidx + ADDR_W'(1);
            left_in    = count_m1 - CNT_W'(tidx);
            state_in   = S_MOVE;
         end
         S_SEARCH: begin
            priority if (pend_ff && (rd_data == val_ff)) begin
               removed_in = rd_data;
               idx_in     = pdst_ff;
               up_in      = 1'b0;
               pend_in    = 1'b0;
               src_in     = tidx + ADDR_W'(1);
               left_in    = count_m1 - CNT_W'(tidx);
               state_in   = S_MOVE;
            end else if (left_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = src_ff;
               pend_in = 1'b1;
               pdst_in = src_ff;
               src_in  = src_ff + ADDR_W'(1);
               left_in = left_ff - CNT_W'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               status_in = ST_NOTFOUND;
               state_in  = S_RD0;
            end
         end
         S_MOVE: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pdst_ff;
               wr_data = rd_data;
            end
            if (left_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = src_ff;
               pend_in = 1'b1;
               pdst_in = up_ff ? (src_ff + ADDR_W'(1)) : (src_ff - ADDR_W'(1));
               src_in  = up_ff ? (src_ff - ADDR_W'(1)) : (src_ff + ADDR_W'(1));
               left_in = left_ff - CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (up_ff) begin
                     state_in = S_PUT;
                  end else begin
                     count_in = count_m1;
                     state_in = S_RD0;
                  end
               end
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = val_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_RD0;
         end
         S_RD0: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_RD1;
         end
         S_RD1: begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(count_m1);
            front_in = (count_ff == '0) ? '0 : rd_data;
            state_in = S_RD2;
         end
         S_RD2: begin
            back_in      = (count_ff == '0) ? '0 : rd_data;
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      src_ff     <= src_in;
      left_ff    <= left_in;
      up_ff      <= up_in;
      pdst_ff    <= pdst_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      front_ff   <= front_in;
      back_ff    <= back_in;
   end

   ole_ram #(
      .WIDTH(VAL_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, removed_ff, back_ff, front_ff, ECNT_W'(count_ff), status_ff};

   `OLE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `OLE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready)
   `OLE_ASSERT_SAME(a_valid_in_resp, clock, reset, rsp_tvalid, state_ff == S_RESP)
   `OLE_ASSERT_SAME(a_no_rw_clash, clock, reset, wr_en && rd_en, wr_addr != rd_addr)
   `OLE_ASSERT_SAME(a_full_status, clock, reset, rsp_tvalid && (status_ff == ST_FULL),
      count_ff == CNT_W'(CAPACITY))
endmodule
`default_nettype wire

>>> hdl/ole_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the ordered list engine: directed and random operation streams.
`timescale 1ns / 1ps

module tb;
   import ole_pkg::*;

   localparam logic [OP_W-1:0] OP_IDLE_A  = 3'd6;
   localparam logic [OP_W-1:0] OP_IDLE_B  = 3'd7;
   localparam int              RAND_ITEMS = 1450;
   localparam int              DRAIN_WAIT = 2 * CAPACITY + 40;
   localparam int              CYCLE_CAP  = 600000;

   typedef struct {
      logic [OP_W-1:0]  opcode;
      logic [VAL_W-1:0] item_value;
      logic [POS_W-1:0] position;
      bit               hold_for_drain;
   } list_op_type;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [ECNT_W-1:0] entry_count;
      logic [VAL_W-1:0]  front_value;
      logic [VAL_W-1:0]  back_value;
      logic [VAL_W-1:0]  removed_value;
   } list_status_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   list_op_type     op_queue[$];
   list_status_type status_queue[$];
   logic [VAL_W-1:0] shadow_list[$];

   int  errors       = 0;
   int  cycles       = 0;
   int  ops_sent     = 0;
   int  rsp_seen     = 0;
   int  full_hits    = 0;
   int  empty_hits   = 0;
   int  miss_hits    = 0;
   int  peak_count   = 0;
   int  send_gap     = 0;
   int  recv_stall   = 0;
   bit  send_burst   = 1'b0;
   bit  recv_burst   = 1'b0;

   ordered_list_engine_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_op_type make_op(logic [OP_W-1:0] opcode, logic [VAL_W-1:0] value,
                                           logic [POS_W-1:0] position, bit hold = 1'b0);
      list_op_type op;
      op.opcode         = opcode;
      op.item_value     = value;
      op.position       = position;
      op.hold_for_drain = hold;
      return op;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      logic [VAL_W-1:0] pool[8];
      pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h1, 32'h5, 32'h64, 32'hFFFF_FF9C};
      if ($urandom_range(0, 9) < 6)
         return pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   // apply one operation to the shadow list and return the status it reports
   function automatic list_status_type apply_list_op(list_op_type op);
      list_status_type st;
      int              at;
      int              hit;
      st.status        = ST_OK;
      st.removed_value = '0;
      hit              = -1;
      if (op.opcode <= OP_INS_POS) begin
         if (shadow_list.size() >= CAPACITY) begin
            st.status = ST_FULL;
            full_hits++;
         end else if (op.opcode == OP_INS_FRONT) begin
            shadow_list.push_front(op.item_value);
         end else if (op.opcode == OP_INS_BACK) begin
            shadow_list.push_back(op.item_value);
         end else if (op.position[POS_W-1] || shadow_list.size() == 0) begin
            shadow_list.push_front(op.item_value);
         end else begin
            at = int'(op.position);
            if (at > shadow_list.size() - 1)
               at = shadow_list.size() - 1;
            shadow_list.insert(at + 1, op.item_value);
         end
      end else if (op.opcode <= OP_DEL_KEY) begin
         if (shadow_list.size() == 0) begin
            st.status = ST_EMPTY;
            empty_hits++;
         end else if (op.opcode == OP_DEL_FRONT) begin
            st.removed_value = shadow_list.pop_front();
         end else if (op.opcode == OP_DEL_BACK) begin
            st.removed_value = shadow_list.pop_back();
         end else begin
            for (int i = 0; i < shadow_list.size(); i++)
               if (hit < 0 && shadow_list[i] == op.item_value)
                  hit = i;
            if (hit >= 0) begin
               st.removed_value = shadow_list[hit];
               shadow_list.delete(hit);
            end else begin
               st.status = ST_NOTFOUND;
               miss_hits++;
            end
         end
      end
      if (shadow_list.size() > peak_count)
         peak_count = shadow_list.size();
      st.entry_count = ECNT_W'(shadow_list.size());
      st.front_value = (shadow_list.size() != 0) ? shadow_list[0] : '0;
      st.back_value  = (shadow_list.size() != 0) ? shadow_list[$] : '0;
      return st;
   endfunction

   task automatic check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      list_op_type op;
      bit          fire;
      bit          valid_next;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         fire       = req_tvalid && req_tready;
         valid_next = req_tvalid;
         if (fire) begin
            op.opcode     = req_tdata[OP_W-1:0];
            op.item_value = req_tdata[OP_W +: VAL_W];
            op.position   = req_tdata[OP_W+VAL_W +: POS_W];
            status_queue.push_back(apply_list_op(op));
            ops_sent++;
            if ($urandom_range(0, 39) == 0)
               send_burst = ~send_burst;
            send_gap = draw_wait(send_burst);
         end
         if (fire || !req_tvalid) begin
            valid_next = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (op_queue.size() != 0 &&
                         !(op_queue[0].hold_for_drain && status_queue.size() != 0)) begin
               op = op_queue.pop_front();
               req_tdata  <= {op.position, op.item_value, op.opcode};
               valid_next = 1'b1;
            end
         end
         req_tvalid <= valid_next;
      end
   end

   // monitor
   always @(posedge clock) begin
      list_status_type exp_st;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (status_queue.size() == 0) begin
               $error("response with no outstanding operation: %0h", rsp_tdata);
               errors++;
            end else begin
               exp_st = status_queue.pop_front();
               check_field("status",        exp_st.status,        rsp_tdata[1:0]);
               check_field("entry_count",   exp_st.entry_count,   rsp_tdata[6:2]);
               check_field("front_value",   exp_st.front_value,   rsp_tdata[38:7]);
               check_field("back_value",    exp_st.back_value,    rsp_tdata[70:39]);
               check_field("removed_value", exp_st.removed_value, rsp_tdata[102:71]);
            end
            if ($urandom_range(0, 39) == 0)
               recv_burst = ~recv_burst;
            recv_stall = draw_wait(recv_burst);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int               ins_pct;
      int               pick;
      logic [OP_W-1:0]  opcode;
      logic [POS_W-1:0] position;

      op_queue.push_back(make_op(OP_DEL_FRONT, 32'h0, 5'd0));
      op_queue.push_back(make_op(OP_DEL_BACK,  32'h0, 5'd0));
      op_queue.push_back(make_op(OP_DEL_KEY,   32'h0, 5'd0));
      op_queue.push_back(make_op(OP_IDLE_A,    32'hFFFF_FFFF, 5'h1F));
      op_queue.push_back(make_op(OP_INS_POS,   32'h7, 5'd3));
      op_queue.push_back(make_op(OP_DEL_KEY,   32'h7, 5'd0));
      op_queue.push_back(make_op(OP_INS_FRONT, 32'h8000_0000, 5'd0));
      op_queue.push_back(make_op(OP_INS_BACK,  32'h7FFF_FFFF, 5'd0));
      op_queue.push_back(make_op(OP_INS_POS,   32'h1, 5'h1F));
      op_queue.push_back(make_op(OP_INS_POS,   32'h2, 5'd0));
      op_queue.push_back(make_op(OP_INS_POS,   32'h3, 5'd15));
      op_queue.push_back(make_op(OP_INS_POS,   32'h4, 5'h10));
      op_queue.push_back(make_op(OP_IDLE_B,    32'h0, 5'd0));
      op_queue.push_back(make_op(OP_DEL_KEY,   32'd12345, 5'd0));
      op_queue.push_back(make_op(OP_DEL_KEY,   32'h2, 5'd0));
      op_queue.push_back(make_op(OP_INS_BACK,  32'h1, 5'd0));
      op_queue.push_back(make_op(OP_DEL_KEY,   32'h1, 5'd0));
      op_queue.push_back(make_op(OP_DEL_FRONT, 32'h0, 5'd0));
      op_queue.push_back(make_op(OP_DEL_BACK,  32'h0, 5'd0));
      op_queue.push_back(make_op(OP_INS_POS,   32'hFFFF_FFFF, 5'd1));

      ins_pct = 50;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 50 == 0)
            case ($urandom_range(0, 2))
               0:       ins_pct = 15;
               1:       ins_pct = 50;
               default: ins_pct = 85;
            endcase
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            opcode = $urandom_range(0, 1) ? OP_IDLE_A : OP_IDLE_B;
         end else if (pick < 3 + ins_pct) begin
            case ($urandom_range(0, 2))
               0:       opcode = OP_INS_FRONT;
               1:       opcode = OP_INS_BACK;
               default: opcode = OP_INS_POS;
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0:       opcode = OP_DEL_FRONT;
               1:       opcode = OP_DEL_BACK;
               default: opcode = OP_DEL_KEY;
            endcase
         end
         position = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 31))
                                                : POS_W'($urandom_range(0, 15));
         op_queue.push_back(make_op(opcode, pick_value(), position,
                                    n == 0 || n == RAND_ITEMS / 2));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (op_queue.size() == 0 && !req_tvalid && status_queue.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (op_queue.size() != 0 || req_tvalid) begin
         $error("%0d operations never sent", op_queue.size() + int'(req_tvalid));
         errors++;
      end
      if (status_queue.size() != 0) begin
         $error("%0d responses never arrived", status_queue.size());
         errors++;
      end

      $display("%0d operations, %0d responses, peak depth %0d of %0d",
               ops_sent, rsp_seen, peak_count, CAPACITY);
      $display("full refusals %0d, empty deletes %0d, key misses %0d, errors %0d",
               full_hits, empty_hits, miss_hits, errors);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
